FILE: hw/rtl/rlmd_pkg.sv
// ----------------------------------------------------------------------------
// Revolution-limited motor drive: shared types and constants
// Request/response payloads, command codes, register map and the divider
// handshake used between the top level and the speed scaler.
// ----------------------------------------------------------------------------
package rlmd_pkg;

   // Fixed field widths of the request and response items
   localparam int OUT_MOTORS  = 4;
   localparam int OUT_IDX_W   = 2;
   localparam int SPEED_W     = 8;
   localparam int DUTY_W      = 8;
   localparam int REVS_W      = 8;
   localparam int ENC_FIELD_W = 16;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 3;

   // Register map: indexes below OUT_MOTORS are the per-motor divisors
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVISOR_END      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTS_PER_ROUND = 3'd4;

   localparam logic [CFG_W-1:0]  DIVISOR_RESET = 16'd256;
   localparam logic [CFG_W-1:0]  CPR_RESET     = 16'd1024;
   localparam logic [DUTY_W-1:0] DUTY_MAX      = 8'd255;

   // Quotient bits produced by the scaler, one per step
   localparam int DIV_STEPS   = DUTY_W;
   localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      CMD_RUN   = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_CHECK = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]             command;
      logic [1:0]             motor_index;
      logic [SPEED_W-1:0]     speed;
      logic                   forward;
      logic [REVS_W-1:0]      revolutions;
      logic [ENC_FIELD_W-1:0] encoder_m0;
      logic [ENC_FIELD_W-1:0] encoder_m1;
      logic [ENC_FIELD_W-1:0] encoder_m2;
      logic [ENC_FIELD_W-1:0] encoder_m3;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]     fwd_duty_m0;
      logic [DUTY_W-1:0]     rev_duty_m0;
      logic [DUTY_W-1:0]     fwd_duty_m1;
      logic [DUTY_W-1:0]     rev_duty_m1;
      logic [DUTY_W-1:0]     fwd_duty_m2;
      logic [DUTY_W-1:0]     rev_duty_m2;
      logic [DUTY_W-1:0]     fwd_duty_m3;
      logic [DUTY_W-1:0]     rev_duty_m3;
      logic [OUT_MOTORS-1:0] reached_mask;
      logic [OUT_MOTORS-1:0] tracking_mask;
   } rsp_type;

   // Scaler handshake
   typedef struct packed {
      logic               start;
      logic [SPEED_W-1:0] speed;
      logic [CFG_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/rlmd_div.sv
// ----------------------------------------------------------------------------
// Speed scaler
// Saturating floor(speed * 256 / divisor), one restoring-division step per
// cycle. Saturates to 255 (also for a zero divisor) without the division steps.
// ----------------------------------------------------------------------------
module rlmd_div
   import rlmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [CFG_W-1:0]      rem_ff;
   logic [CFG_W-1:0]      div_ff;
   logic [DUTY_W-1:0]     quo_ff;

   logic [CFG_W:0]        shift_in;
   logic                  bit_in;
   logic [CFG_W-1:0]      rem_in;

   // One shift / compare / subtract step
   always_comb begin
      shift_in = {rem_ff, 1'b0};
      bit_in   = (shift_in >= {1'b0, div_ff});
      rem_in   = bit_in ? CFG_W'(shift_in - {1'b0, div_ff}) : CFG_W'(shift_in);
   end

   // Sequencer: quotient reaches 256 exactly when speed >= divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         if (div_req.start) begin
            div_ff  <= div_req.divisor;
            step_ff <= '0;
            if ({{(CFG_W-SPEED_W){1'b0}}, div_req.speed} >= div_req.divisor) begin
               quo_ff  <= DUTY_MAX;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= {{(CFG_W-SPEED_W){1'b0}}, div_req.speed};
               quo_ff  <= '0;
               busy_ff <= 1'b1;
               done_ff <= 1'b0;
            end
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[DUTY_W-2:0], bit_in};
            step_ff <= step_ff + 1'b1;
            // last step ends the division
            busy_ff <= (step_ff != DIV_STEP_W'(DIV_STEPS - 1));
            done_ff <= (step_ff == DIV_STEP_W'(DIV_STEPS - 1));
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/revolution_limited_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// Revolution-limited motor drive
// Four H-bridge duty pairs with per-motor revolution limits on encoder counts.
// ----------------------------------------------------------------------------
// After accept: a run waits for the scaler (no division steps when the speed
//   saturates), a stop acts directly and a check walks every motor in turn.
// One request at a time, taken the cycle after the response is loaded into the
//   output register; the 8-step scaler, the check and receiver stalls set the pace.
// Reset (synchronous): all duties, tracking and targets zero, divisors 256,
//   counts per revolution 1024, no response pending.
module revolution_limited_motor_drive_unit
   import rlmd_pkg::*;
#(
   parameter int MOTOR_COUNT  = 4,
   parameter int ENCODER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int NEED_W = REVS_W + CFG_W;
   localparam int CMP_W  = (ENCODER_BITS > NEED_W) ? ENCODER_BITS : NEED_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_CHECK,
      S_DONE
   } state_type;

   state_type                 state_ff;
   req_type                   req_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;
   logic [CFG_W-1:0]          divisor_ff [OUT_MOTORS];
   logic [CFG_W-1:0]          cpr_ff;
   logic [DUTY_W-1:0]         fwd_duty_ff [MOTOR_COUNT];
   logic [DUTY_W-1:0]         rev_duty_ff [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0]    tracking_ff;
   logic [MOTOR_COUNT-1:0]    dir_fwd_ff;
   logic [ENCODER_BITS-1:0]   start_ff [MOTOR_COUNT];
   logic [REVS_W-1:0]         target_ff [MOTOR_COUNT];
   logic [MIDX_W-1:0]         chk_ff;
   logic [OUT_MOTORS-1:0]     reached_ff;

   logic [MIDX_W-1:0]         run_idx;
   logic                      idx_ok;
   logic [ENCODER_BITS-1:0]   chk_enc;
   logic [ENCODER_BITS-1:0]   distance;
   logic [NEED_W-1:0]         need;
   logic                      hit;
   logic                      rsp_load;
   div_req_type               div_req;
   div_rsp_type               div_rsp;
   rsp_type                   rsp_in;
   logic [DUTY_W-1:0]         fwd_pad [OUT_MOTORS];
   logic [DUTY_W-1:0]         rev_pad [OUT_MOTORS];
   logic [OUT_MOTORS-1:0]     trk_pad;

   // Encoder count of one motor; motors without an encoder field read zero
   function automatic logic [ENCODER_BITS-1:0] enc_pick(req_type r, logic [MIDX_W-1:0] m);
      logic [ENCODER_BITS-1:0] e;
      case (int'(m))
         0:       e = ENCODER_BITS'(r.encoder_m0);
         1:       e = ENCODER_BITS'(r.encoder_m1);
         2:       e = ENCODER_BITS'(r.encoder_m2);
         3:       e = ENCODER_BITS'(r.encoder_m3);
         default: e = '0;
      endcase
      return e;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign run_idx = MIDX_W'(req_ff.motor_index);
   assign idx_ok  = (int'(req_ff.motor_index) < MOTOR_COUNT);

   // Shared distance / threshold compare for the motor under check
   always_comb begin
      chk_enc  = enc_pick(req_ff, chk_ff);
      distance = dir_fwd_ff[chk_ff] ? (chk_enc - start_ff[chk_ff])
                                    : (start_ff[chk_ff] - chk_enc);
      need     = NEED_W'(target_ff[chk_ff]) * NEED_W'(cpr_ff);
      hit      = (CMP_W'(distance) >= CMP_W'(need));
   end

   // Speed scaler
   assign div_req.start   = (state_ff == S_EXEC) && (req_ff.command == CMD_RUN) && idx_ok;
   assign div_req.speed   = req_ff.speed;
   assign div_req.divisor = divisor_ff[req_ff.motor_index];

   rlmd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Map motor state onto the four response slots
   for (genvar g = 0; g < OUT_MOTORS; g++) begin : g_out
      if (g < MOTOR_COUNT) begin : g_on
         assign fwd_pad[g] = fwd_duty_ff[g];
         assign rev_pad[g] = rev_duty_ff[g];
         assign trk_pad[g] = tracking_ff[g];
      end else begin : g_off
         assign fwd_pad[g] = '0;
         assign rev_pad[g] = '0;
         assign trk_pad[g] = 1'b0;
      end
   end

   always_comb begin
      rsp_in.fwd_duty_m0   = fwd_pad[0];
      rsp_in.rev_duty_m0   = rev_pad[0];
      rsp_in.fwd_duty_m1   = fwd_pad[1];
      rsp_in.rev_duty_m1   = rev_pad[1];
      rsp_in.fwd_duty_m2   = fwd_pad[2];
      rsp_in.rev_duty_m2   = rev_pad[2];
      rsp_in.fwd_duty_m3   = fwd_pad[3];
      rsp_in.rev_duty_m3   = rev_pad[3];
      rsp_in.reached_mask  = reached_ff;
      rsp_in.tracking_mask = trk_pad;
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OUT_MOTORS; i++) begin
            divisor_ff[i] <= DIVISOR_RESET;
         end
         cpr_ff <= CPR_RESET;
      end else if (csr_valid) begin
         if (csr_index < CSR_DIVISOR_END) begin
            divisor_ff[csr_index[OUT_IDX_W-1:0]] <= csr_data;
         end else if (csr_index == CSR_COUNTS_PER_ROUND) begin
            cpr_ff <= csr_data;
         end
      end
   end

   // Request and response payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Sequencer and motor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tracking_ff  <= '0;
         dir_fwd_ff   <= '0;
         chk_ff       <= '0;
         reached_ff   <= '0;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            fwd_duty_ff[i] <= '0;
            rev_duty_ff[i] <= '0;
            start_ff[i]    <= '0;
            target_ff[i]   <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               reached_ff <= '0;
               chk_ff     <= '0;
               case (cmd_type'(req_ff.command))
                  CMD_RUN: begin
                     state_ff <= idx_ok ? S_DIV : S_DONE;
                  end
                  CMD_STOP: begin
                     if (idx_ok) begin
                        fwd_duty_ff[run_idx] <= '0;
                        rev_duty_ff[run_idx] <= '0;
                        tracking_ff[run_idx] <= 1'b0;
                        dir_fwd_ff[run_idx]  <= 1'b0;
                        target_ff[run_idx]   <= '0;
                     end
                     state_ff <= S_DONE;
                  end
                  CMD_CHECK: begin
                     state_ff <= S_CHECK;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_DIV: begin
               // scaled value on the chosen leg; a nonzero revolution count replaces the old target
               if (div_rsp.done) begin
                  fwd_duty_ff[run_idx] <= req_ff.forward ? div_rsp.quotient : '0;
                  rev_duty_ff[run_idx] <= req_ff.forward ? '0 : div_rsp.quotient;
                  if (req_ff.revolutions != '0) begin
                     tracking_ff[run_idx] <= 1'b1;
                     dir_fwd_ff[run_idx]  <= req_ff.forward;
                     start_ff[run_idx]    <= enc_pick(req_ff, run_idx);
                     target_ff[run_idx]   <= req_ff.revolutions;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_CHECK: begin
               // one motor per cycle
               if (tracking_ff[chk_ff] && hit) begin
                  fwd_duty_ff[chk_ff] <= '0;
                  rev_duty_ff[chk_ff] <= '0;
                  tracking_ff[chk_ff] <= 1'b0;
                  dir_fwd_ff[chk_ff]  <= 1'b0;
                  target_ff[chk_ff]   <= '0;
                  reached_ff <= reached_ff | ({{(OUT_MOTORS-1){1'b0}}, 1'b1} << chk_ff);
               end
               if (chk_ff == MIDX_W'(MOTOR_COUNT - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  chk_ff <= chk_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // output register handshake
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: hw/rtl/rlmd_checker.sv
// ----------------------------------------------------------------------------
// Revolution-limited motor drive: port checker
// Watches the top-level ports for handshake and duty consistency.
// ----------------------------------------------------------------------------
module rlmd_checker
   import rlmd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input req_type                req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_payload,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CFG_W-1:0]       csr_data
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // One request at a time: not ready right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A motor never drives both legs
   a_one_leg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_payload.fwd_duty_m0 == '0 || rsp_payload.rev_duty_m0 == '0) &&
         (rsp_payload.fwd_duty_m1 == '0 || rsp_payload.rev_duty_m1 == '0) &&
         (rsp_payload.fwd_duty_m2 == '0 || rsp_payload.rev_duty_m2 == '0) &&
         (rsp_payload.fwd_duty_m3 == '0 || rsp_payload.rev_duty_m3 == '0))
      else $error("both legs driven");

   // A motor reported as reached is stopped and no longer tracked
   a_reached_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_payload.reached_mask & rsp_payload.tracking_mask) == '0) &&
         (!rsp_payload.reached_mask[0] ||
            (rsp_payload.fwd_duty_m0 == '0 && rsp_payload.rev_duty_m0 == '0)) &&
         (!rsp_payload.reached_mask[1] ||
            (rsp_payload.fwd_duty_m1 == '0 && rsp_payload.rev_duty_m1 == '0)) &&
         (!rsp_payload.reached_mask[2] ||
            (rsp_payload.fwd_duty_m2 == '0 && rsp_payload.rev_duty_m2 == '0)) &&
         (!rsp_payload.reached_mask[3] ||
            (rsp_payload.fwd_duty_m3 == '0 && rsp_payload.rev_duty_m3 == '0)))
      else $error("reached motor still running");

endmodule

bind revolution_limited_motor_drive_unit rlmd_checker u_rlmd_checker (.*);

FILE: test/tb_revolution_limited_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// Revolution-limited motor drive testbench
// Drives run, stop, check and unknown requests through the valid/ready port,
// tracks duties, revolution targets and encoder start counts in a class, and
// checks every response field. Divisors and counts per revolution are
// rewritten between phases, and idle and stall rates rotate through four settings.
// ----------------------------------------------------------------------------
module tb_revolution_limited_motor_drive_unit;
   import rlmd_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES = 16;
   localparam int PHASE_REQUESTS = 50;
   localparam int REPORT_LIMIT = 200;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;

   // Duty, tracking and configuration state plus pending responses
   class motor_drive_tracker;
      logic [DUTY_W-1:0]      fwd[OUT_MOTORS];
      logic [DUTY_W-1:0]      rev[OUT_MOTORS];
      bit                     tracking[OUT_MOTORS];
      bit                     cnt_fwd[OUT_MOTORS];
      logic [ENC_FIELD_W-1:0] start[OUT_MOTORS];
      logic [REVS_W-1:0]      target[OUT_MOTORS];
      logic [CFG_W-1:0]       divisor[OUT_MOTORS];
      logic [CFG_W-1:0]       cpr;
      rsp_type                expected_duties[$];
      int                     errors;

      function new();
         for (int m = 0; m < OUT_MOTORS; m++) begin
            fwd[m] = '0;
            rev[m] = '0;
            tracking[m] = 1'b0;
            cnt_fwd[m] = 1'b0;
            start[m] = '0;
            target[m] = '0;
            divisor[m] = DIVISOR_RESET;
         end
         cpr = CPR_RESET;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx < CSR_DIVISOR_END)
            divisor[idx] = val;
         else if (idx == CSR_COUNTS_PER_ROUND)
            cpr = val;
      endfunction

      function logic [DUTY_W-1:0] scaled_speed(logic [SPEED_W-1:0] speed,
                                              logic [CFG_W-1:0] div);
         logic [15:0] q;
         if (div == '0)
            return DUTY_MAX;
         q = {speed, 8'h00} / div;
         return (q > 16'd255) ? DUTY_MAX : q[7:0];
      endfunction

      function void halt(int m);
         fwd[m] = '0;
         rev[m] = '0;
         tracking[m] = 1'b0;
         cnt_fwd[m] = 1'b0;
         target[m] = '0;
      endfunction

      // Update state for an accepted request and queue the response it causes
      function void apply_request(req_type r);
         logic [ENC_FIELD_W-1:0] enc[OUT_MOTORS];
         logic [ENC_FIELD_W-1:0] distance;
         logic [DUTY_W-1:0]      s;
         int unsigned            need;
         int                     m;
         rsp_type                e;
         logic [OUT_MOTORS-1:0]  reached;
         enc[0] = r.encoder_m0;
         enc[1] = r.encoder_m1;
         enc[2] = r.encoder_m2;
         enc[3] = r.encoder_m3;
         reached = '0;
         m = r.motor_index;
         if (r.command == CMD_RUN) begin
            s = scaled_speed(r.speed, divisor[m]);
            fwd[m] = r.forward ? s : '0;
            rev[m] = r.forward ? '0 : s;
            if (r.revolutions != '0) begin
               tracking[m] = 1'b1;
               cnt_fwd[m] = r.forward;
               start[m] = enc[m];
               target[m] = r.revolutions;
            end
         end else if (r.command == CMD_STOP) begin
            halt(m);
         end else if (r.command == CMD_CHECK) begin
            for (int k = 0; k < OUT_MOTORS; k++) begin
               if (tracking[k]) begin
                  distance = cnt_fwd[k] ? enc[k] - start[k] : start[k] - enc[k];
                  need = target[k] * cpr;
                  if (distance >= need) begin
                     halt(k);
                     reached[k] = 1'b1;
                  end
               end
            end
         end
         e.fwd_duty_m0 = fwd[0];
         e.rev_duty_m0 = rev[0];
         e.fwd_duty_m1 = fwd[1];
         e.rev_duty_m1 = rev[1];
         e.fwd_duty_m2 = fwd[2];
         e.rev_duty_m2 = rev[2];
         e.fwd_duty_m3 = fwd[3];
         e.rev_duty_m3 = rev[3];
         e.reached_mask = reached;
         for (int k = 0; k < OUT_MOTORS; k++)
            e.tracking_mask[k] = tracking[k];
         expected_duties.push_back(e);
      endfunction

      function void to_fields(rsp_type r, output int unsigned f[10]);
         f = '{r.fwd_duty_m0, r.rev_duty_m0, r.fwd_duty_m1, r.rev_duty_m1,
               r.fwd_duty_m2, r.rev_duty_m2, r.fwd_duty_m3, r.rev_duty_m3,
               r.reached_mask, r.tracking_mask};
      endfunction

      // Compare an accepted response with the oldest expectation
      function void check_response(rsp_type got);
         int unsigned exp_f[10];
         int unsigned act_f[10];
         string       name;
         if (expected_duties.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected response %h", $time, got);
            return;
         end
         to_fields(expected_duties.pop_front(), exp_f);
         to_fields(got, act_f);
         for (int i = 0; i < 10; i++) begin
            if (exp_f[i] != act_f[i]) begin
               errors++;
               if (i < 8)
                  name = $sformatf("%s_duty_m%0d", (i % 2) ? "rev" : "fwd", i / 2);
               else
                  name = (i == 8) ? "reached_mask" : "tracking_mask";
               if (errors <= REPORT_LIMIT)
                  $display("%0t: %s expected %0d actual %0d", $time, name,
                           exp_f[i], act_f[i]);
            end
         end
      endfunction

      function int pending();
         return expected_duties.size();
      endfunction
   endclass

   motor_drive_tracker drive = new();

   revolution_limited_motor_drive_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL revolution_limited_motor_drive_unit");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Request and response monitors
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         drive.apply_request(req_payload);
      if (!reset && rsp_valid && rsp_ready)
         drive.check_response(rsp_payload);
   end

   function req_type make_request(logic [1:0] cmd, logic [1:0] idx, logic [7:0] speed,
                                  logic fwd, logic [7:0] revs, logic [15:0] e0,
                                  logic [15:0] e1, logic [15:0] e2, logic [15:0] e3);
      req_type r;
      r.command = cmd;
      r.motor_index = idx;
      r.speed = speed;
      r.forward = fwd;
      r.revolutions = revs;
      r.encoder_m0 = e0;
      r.encoder_m1 = e1;
      r.encoder_m2 = e2;
      r.encoder_m3 = e3;
      return r;
   endfunction

   // Random request; checks mostly aim encoders at the tracked targets
   function req_type random_request();
      logic [15:0] enc[OUT_MOTORS];
      logic [1:0]  cmd;
      logic [7:0]  revs;
      int          pick;
      int          need;
      int          delta;
      pick = $urandom_range(99);
      if (pick < 35)
         cmd = CMD_RUN;
      else if (pick < 45)
         cmd = CMD_STOP;
      else if (pick < 94)
         cmd = CMD_CHECK;
      else
         cmd = CMD_UNKNOWN;
      pick = $urandom_range(99);
      if (pick < 20)
         revs = '0;
      else if (pick < 75)
         revs = 8'($urandom_range(1, 6));
      else
         revs = 8'($urandom);
      for (int m = 0; m < OUT_MOTORS; m++) begin
         enc[m] = 16'($urandom);
         if (cmd == CMD_CHECK && drive.tracking[m] && $urandom_range(99) < 70) begin
            need = drive.target[m] * drive.cpr;
            if (need < 65536) begin
               delta = need + $urandom_range(4) - 2;
               enc[m] = drive.cnt_fwd[m] ? drive.start[m] + 16'(delta)
                                         : drive.start[m] - 16'(delta);
            end
         end
      end
      return make_request(cmd, 2'($urandom), 8'($urandom), 1'($urandom), revs,
                          enc[0], enc[1], enc[2], enc[3]);
   endfunction

   // Present one request and hold it until taken; valid stays high afterwards
   task send_request(req_type r);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding response
   task drain_requests();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (drive.pending() != 0);
   endtask

   task write_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      drive.set_register(idx, val);
   endtask

   // Register settings per phase, extremes in the first few
   task configure_drive(int phase);
      logic [CFG_W-1:0] div[OUT_MOTORS];
      logic [CFG_W-1:0] cpr;
      case (phase)
         0: begin
            div = '{DIVISOR_RESET, DIVISOR_RESET, DIVISOR_RESET, DIVISOR_RESET};
            cpr = CPR_RESET;
         end
         1: begin
            // zero divisor saturates every speed, zero included
            div = '{16'd0, 16'd1, 16'd65535, 16'd256};
            cpr = 16'd1;
         end
         2: begin
            div = '{16'd65535, 16'd65535, 16'd65535, 16'd65535};
            cpr = 16'd65535;
         end
         3: begin
            div = '{16'd1, 16'd128, 16'd0, 16'd512};
            cpr = 16'd65535;
         end
         default: begin
            for (int m = 0; m < OUT_MOTORS; m++)
               div[m] = ($urandom_range(99) < 10) ? 16'd65535 : 16'($urandom_range(1, 1024));
            cpr = ($urandom_range(99) < 10) ? 16'd1 : 16'($urandom_range(1, 3000));
         end
      endcase
      for (int m = 0; m < OUT_MOTORS; m++)
         write_register(CSR_INDEX_W'(m), div[m]);
      write_register(CSR_COUNTS_PER_ROUND, cpr);
      csr_valid <= 1'b0;
   endtask

   // Directed sequence with reset divisors (1.0) and 1024 counts per revolution
   task run_directed();
      send_request(make_request(CMD_RUN, 2'd0, 8'd255, 1'b1, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      // reverse leg, widest target, start at the top of the encoder range
      send_request(make_request(CMD_RUN, 2'd1, 8'd0, 1'b0, 8'd255,
                                16'h0, 16'hFFFF, 16'h0, 16'h0));
      send_request(make_request(CMD_RUN, 2'd2, 8'd128, 1'b1, 8'd1,
                                16'h0, 16'h0, 16'hFFF0, 16'h0));
      // one count short across the wrap, then exactly on target
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0,
                                16'hFFFF, 16'hFFFF, 16'h03EF, 16'hFFFF));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0,
                                16'hFFFF, 16'hFFFF, 16'h03F0, 16'hFFFF));
      // a second run replaces target and start count
      send_request(make_request(CMD_RUN, 2'd3, 8'd77, 1'b0, 8'd2, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_RUN, 2'd3, 8'd200, 1'b0, 8'd3,
                                16'h0, 16'h0, 16'h0, 16'h1000));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0,
                                16'h0, 16'hFFFF, 16'h0, 16'h0800));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0,
                                16'h0, 16'hFFFF, 16'h0, 16'h0400));
      // zero revolutions leaves the forward count running while the leg flips
      send_request(make_request(CMD_RUN, 2'd0, 8'd10, 1'b1, 8'd5,
                                16'hABCD, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_RUN, 2'd0, 8'd99, 1'b0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0,
                                16'hBFCD, 16'hFFFF, 16'h1234, 16'h0));
      // two motors reach on the same check
      send_request(make_request(CMD_RUN, 2'd2, 8'd33, 1'b1, 8'd1,
                                16'h0, 16'h0, 16'h0100, 16'h0));
      send_request(make_request(CMD_RUN, 2'd3, 8'd44, 1'b0, 8'd1,
                                16'h0, 16'h0, 16'h0, 16'h0100));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0,
                                16'h0, 16'hFFFF, 16'h0500, 16'hFD00));
      send_request(make_request(CMD_STOP, 2'd1, 8'd0, 1'b0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_RUN, 2'd1, 8'd1, 1'b1, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_UNKNOWN, 2'd3, 8'hFF, 1'b1, 8'hFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_request(make_request(CMD_STOP, 2'd2, 8'd0, 1'b0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_RUN, 2'd0, 8'd255, 1'b0, 8'd255,
                                16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_STOP, 2'd0, 8'd0, 1'b0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_request(make_request(CMD_CHECK, 2'd0, 8'd0, 1'b0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0));
   endtask

   // Main sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         drain_requests();
         configure_drive(p);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         repeat (PHASE_REQUESTS) send_request(random_request());
      end
      drain_requests();
      repeat (20) @(posedge clock);
      if (drive.errors == 0 && drive.pending() == 0)
         $display("PASS revolution_limited_motor_drive_unit");
      else
         $display("FAIL revolution_limited_motor_drive_unit");
      $finish;
   end

endmodule
